/* rtl/text_console_writer_unit_macros.svh */
// Assertion macros for the text console writer.
// Used by the top level; each macro expects clk and rst_n in scope.
`ifndef TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tcw_pkg.sv */
// Shared constants, codes and types of the text console writer.
// No dependencies; imported by tcw_divmod, text_console_writer_unit, console_checker and tb_top.
package tcw_pkg;

    // Screen geometry.
    localparam int COLUMNS    = 80;
    localparam int CELLS      = 2000;
    localparam int TAB_STOP   = 8;
    localparam int MOVE_CELLS = CELLS - COLUMNS;

    // Widths: cursor holds 0..CELLS, a cell address 0..CELLS-1.
    localparam int CW   = $clog2(CELLS + 1);
    localparam int AW   = $clog2(CELLS);
    localparam int COLW = $clog2(COLUMNS);
    localparam int TW   = $clog2(TAB_STOP);

    // Reciprocals for remainder by constant; quotient is exact or one low.
    localparam int COL_RECIP = (1 << CW) / COLUMNS;
    localparam int TAB_RECIP = (1 << CW) / TAB_STOP;

    // Cell words.
    localparam logic [15:0] CURSOR_WORD = 16'hF000;
    localparam logic [15:0] BLANK_WORD  = 16'h0000;
    localparam logic [15:0] CLEAR_WORD  = 16'h0F20;

    // Control characters.
    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_NL  = 8'd10;

    // Command codes.
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_MOD,
        ST_CTRL,
        ST_SCROLL,
        ST_ZERO,
        ST_WRITE_CH,
        ST_PAINT,
        ST_FILL,
        ST_READ
    } state_t;

    // Cursor column and position within the current tab stop.
    typedef struct packed {
        logic [COLW-1:0] col;
        logic [TW-1:0]   trem;
    } cursor_mods_t;

endpackage

/* rtl/tcw_divmod.sv */
// Two-stage remainder unit: cursor mod COLUMNS and cursor mod TAB_STOP.
// Depends on tcw_pkg. The input and quotient estimates are registered, then the remainders.
module tcw_divmod (
    input  logic                    clk,
    input  logic [tcw_pkg::CW-1:0]  value,
    output tcw_pkg::cursor_mods_t   mods
);
    import tcw_pkg::*;

    logic [2*CW-1:0] prod_col;
    logic [2*CW-1:0] prod_tab;
    logic [CW-1:0]   value_reg;
    logic [CW-1:0]   qcol_reg;
    logic [CW-1:0]   qtab_reg;
    logic [CW-1:0]   rcol_raw;
    logic [CW-1:0]   rtab_raw;
    logic [CW-1:0]   rcol;
    logic [CW-1:0]   rtab;
    cursor_mods_t    mods_reg;
    cursor_mods_t    mods_next;

    // First stage: estimate quotients by multiplying with the reciprocals.
    assign prod_col = (2*CW)'(value) * (2*CW)'(COL_RECIP);
    assign prod_tab = (2*CW)'(value) * (2*CW)'(TAB_RECIP);

    // Second stage: remainder from the estimate, with one correction step.
    always_comb
    begin
        rcol_raw = value_reg - qcol_reg * CW'(COLUMNS);
        rtab_raw = value_reg - qtab_reg * CW'(TAB_STOP);
        rcol     = (rcol_raw >= CW'(COLUMNS)) ? rcol_raw - CW'(COLUMNS) : rcol_raw;
        rtab     = (rtab_raw >= CW'(TAB_STOP)) ? rtab_raw - CW'(TAB_STOP) : rtab_raw;
        mods_next.col  = rcol[COLW-1:0];
        mods_next.trem = rtab[TW-1:0];
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value;
        qcol_reg  <= prod_col[2*CW-1:CW];
        qtab_reg  <= prod_tab[2*CW-1:CW];
        mods_reg  <= mods_next;
    end

    assign mods = mods_reg;

endmodule

/* rtl/text_console_writer_unit.sv */
// Text console writer: screen store of 16-bit cells with a flat cursor.
// Depends on tcw_pkg, tcw_divmod and text_console_writer_unit_macros.svh.

// A command is taken when start is high and busy is low; exactly one result
// comes back on done for one cycle, and the receiver cannot stall it. After
// reset the block sweeps the screen store to zero, one cell per clock, and busy
// stays high until the sweep is done. The store is a single memory with one
// write and one read port, and that port sets the order of steps: a printable
// character writes the character, then draws the cursor; backspace, tab and
// newline first wait for the cursor column and tab position from the two-stage
// remainder unit, then erase the old cursor and move it, then draw it; a
// backspace at column 0 ends after the wait with no change. A read fetches the
// cell through the registered port and then returns it, and an unused command
// is answered from the idle state. A put that has to scroll first copies every
// row up through the memory port and zero-fills the last row; a printable
// character is written after the scroll. A clear fills all CELLS cells and then draws the cursor.
`include "text_console_writer_unit_macros.svh"

module text_console_writer_unit (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              cmd,
    input  logic [7:0]              ch,
    input  logic [3:0]              background,
    input  logic [3:0]              foreground,
    input  logic [tcw_pkg::CW-1:0]  cell_index,
    output logic                    done,
    output logic [tcw_pkg::CW-1:0]  cursor_index,
    output logic [15:0]             read_data,
    output logic                    scrolled
);
    import tcw_pkg::*;

    // Control state.
    state_t         state_reg;
    state_t         state_next;
    logic [CW-1:0]  cursor_reg;
    logic [CW-1:0]  cursor_next;
    logic [CW-1:0]  ptr_reg;
    logic [CW-1:0]  ptr_next;
    logic           copy_pend_reg;
    logic           copy_pend_next;
    logic           scroll_flag_reg;
    logic           scroll_flag_next;
    logic           done_reg;
    logic           done_next;

    // Item payload and result registers.
    logic [7:0]     op_ch_reg;
    logic [7:0]     op_ch_next;
    logic [7:0]     op_attr_reg;
    logic [7:0]     op_attr_next;
    logic           rd_ok_reg;
    logic           rd_ok_next;
    logic [CW-1:0]  cursor_index_reg;
    logic [CW-1:0]  cursor_index_next;
    logic [15:0]    read_data_reg;
    logic [15:0]    read_data_next;
    logic           scrolled_reg;
    logic           scrolled_next;

    // Screen store ports.
    logic [15:0]    mem [0:CELLS-1];
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [15:0]    mem_wdata;
    logic [AW-1:0]  mem_raddr;
    logic [15:0]    mem_q_reg;

    // Helpers.
    logic           accept;
    logic           cursor_ok;
    logic           in_ctrl;
    logic           op_ctrl;
    logic           last_cell;
    logic [CW:0]    ctrl_step;
    logic [CW:0]    ctrl_target;
    logic [CW-1:0]  scroll_src;
    logic [CW-1:0]  scroll_dst;
    cursor_mods_t   mods;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cursor_ok = (cursor_reg < CW'(CELLS));
    assign last_cell = (ptr_reg == CW'(CELLS - 1));
    assign in_ctrl   = (ch == CH_BS) || (ch == CH_TAB) || (ch == CH_NL);
    assign op_ctrl   = (op_ch_reg == CH_BS) || (op_ch_reg == CH_TAB) ||
                       (op_ch_reg == CH_NL);

    // Remainders of the cursor by the row length and the tab stop.
    tcw_divmod u_divmod (
        .clk   (clk),
        .value (cursor_reg),
        .mods  (mods)
    );

    // Distance to the next tab stop or row start, and the cursor it gives.
    always_comb
    begin
        if (op_ch_reg == CH_TAB)
        begin
            ctrl_step = (CW+1)'(TAB_STOP) - (CW+1)'(mods.trem);
        end
        else
        begin
            ctrl_step = (CW+1)'(COLUMNS) - (CW+1)'(mods.col);
        end
        ctrl_target = {1'b0, cursor_reg} + ctrl_step;
    end

    // Scroll copy: read a cell one row down, write it one row up in the cycle after.
    assign scroll_src = ptr_reg + CW'(COLUMNS);
    assign scroll_dst = ptr_reg - CW'(1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (last_cell)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd)
                        CMD_PUT:
                        begin
                            if (in_ctrl)
                            begin
                                state_next = ST_MOD;
                            end
                            else if (cursor_ok)
                            begin
                                state_next = ST_PAINT;
                            end
                            else
                            begin
                                state_next = ST_SCROLL;
                            end
                        end
                        CMD_CLEAR: state_next = ST_FILL;
                        CMD_READ:  state_next = ST_READ;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MOD: state_next = ST_CTRL;
            ST_CTRL:
            begin
                priority if (op_ch_reg == CH_BS)
                begin
                    state_next = (mods.col == '0) ? ST_IDLE : ST_PAINT;
                end
                else if (ctrl_target >= (CW+1)'(CELLS))
                begin
                    state_next = ST_SCROLL;
                end
                else
                begin
                    state_next = ST_PAINT;
                end
            end
            ST_SCROLL:
            begin
                if (ptr_reg == CW'(MOVE_CELLS))
                begin
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO:
            begin
                if (last_cell)
                begin
                    state_next = op_ctrl ? ST_PAINT : ST_WRITE_CH;
                end
            end
            ST_WRITE_CH: state_next = ST_PAINT;
            ST_PAINT:    state_next = ST_IDLE;
            ST_FILL:
            begin
                if (last_cell)
                begin
                    state_next = ST_PAINT;
                end
            end
            ST_READ:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory access and results.
    always_comb
    begin
        cursor_next       = cursor_reg;
        ptr_next          = ptr_reg;
        copy_pend_next    = 1'b0;
        scroll_flag_next  = scroll_flag_reg;
        done_next         = 1'b0;
        op_ch_next        = op_ch_reg;
        op_attr_next      = op_attr_reg;
        rd_ok_next        = rd_ok_reg;
        cursor_index_next = cursor_index_reg;
        read_data_next    = read_data_reg;
        scrolled_next     = scrolled_reg;
        mem_we            = 1'b0;
        mem_waddr         = cursor_reg[AW-1:0];
        mem_wdata         = BLANK_WORD;
        mem_raddr         = scroll_src[AW-1:0];

        unique case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg[AW-1:0];
                mem_wdata = BLANK_WORD;
                ptr_next  = last_cell ? '0 : ptr_reg + CW'(1);
            end
            ST_IDLE:
            begin
                mem_raddr = cell_index[AW-1:0];
                if (accept)
                begin
                    op_ch_next       = ch;
                    op_attr_next     = {background, foreground};
                    scroll_flag_next = 1'b0;
                    unique case (cmd)
                        CMD_PUT:
                        begin
                            if (!in_ctrl)
                            begin
                                if (cursor_ok)
                                begin
                                    // Character goes straight in; cursor drawn next.
                                    mem_we      = 1'b1;
                                    mem_wdata   = {background, foreground, ch};
                                    cursor_next = cursor_reg + CW'(1);
                                end
                                else
                                begin
                                    ptr_next = '0;
                                end
                            end
                        end
                        CMD_CLEAR:
                        begin
                            ptr_next = '0;
                        end
                        CMD_READ:
                        begin
                            rd_ok_next = (cell_index < CW'(CELLS));
                        end
                        default:
                        begin
                            done_next         = 1'b1;
                            cursor_index_next = cursor_reg;
                            read_data_next    = '0;
                            scrolled_next     = 1'b0;
                        end
                    endcase
                end
            end
            ST_MOD:
            begin
            end
            ST_CTRL:
            begin
                priority if (op_ch_reg == CH_BS && mods.col == '0)
                begin
                    // Backspace at the row start changes nothing.
                    done_next         = 1'b1;
                    cursor_index_next = cursor_reg;
                    read_data_next    = '0;
                    scrolled_next     = 1'b0;
                end
                else if (op_ch_reg == CH_BS)
                begin
                    mem_we      = cursor_ok;
                    mem_wdata   = BLANK_WORD;
                    cursor_next = cursor_reg - CW'(1);
                end
                else
                begin
                    // Tab or newline: erase the old cursor, then move or scroll.
                    mem_we    = cursor_ok;
                    mem_wdata = BLANK_WORD;
                    if (ctrl_target >= (CW+1)'(CELLS))
                    begin
                        ptr_next = '0;
                    end
                    else
                    begin
                        cursor_next = ctrl_target[CW-1:0];
                    end
                end
            end
            ST_SCROLL:
            begin
                mem_raddr = scroll_src[AW-1:0];
                if (ptr_reg < CW'(MOVE_CELLS))
                begin
                    ptr_next       = ptr_reg + CW'(1);
                    copy_pend_next = 1'b1;
                end
                if (copy_pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = scroll_dst[AW-1:0];
                    mem_wdata = mem_q_reg;
                end
            end
            ST_ZERO:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg[AW-1:0];
                mem_wdata = BLANK_WORD;
                ptr_next  = ptr_reg + CW'(1);
                if (last_cell)
                begin
                    cursor_next      = CW'(MOVE_CELLS);
                    scroll_flag_next = 1'b1;
                end
            end
            ST_WRITE_CH:
            begin
                mem_we      = 1'b1;
                mem_wdata   = {op_attr_reg, op_ch_reg};
                cursor_next = cursor_reg + CW'(1);
            end
            ST_PAINT:
            begin
                // Draw the cursor unless it sits one past the last cell.
                mem_we            = cursor_ok;
                mem_wdata         = CURSOR_WORD;
                done_next         = 1'b1;
                cursor_index_next = cursor_reg;
                read_data_next    = '0;
                scrolled_next     = scroll_flag_reg;
            end
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg[AW-1:0];
                mem_wdata = CLEAR_WORD;
                ptr_next  = ptr_reg + CW'(1);
                if (last_cell)
                begin
                    cursor_next = '0;
                end
            end
            ST_READ:
            begin
                done_next         = 1'b1;
                cursor_index_next = cursor_reg;
                read_data_next    = rd_ok_reg ? mem_q_reg : '0;
                scrolled_next     = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_INIT;
            cursor_reg      <= '0;
            ptr_reg         <= '0;
            copy_pend_reg   <= 1'b0;
            scroll_flag_reg <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cursor_reg      <= cursor_next;
            ptr_reg         <= ptr_next;
            copy_pend_reg   <= copy_pend_next;
            scroll_flag_reg <= scroll_flag_next;
            done_reg        <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_ch_reg        <= op_ch_next;
        op_attr_reg      <= op_attr_next;
        rd_ok_reg        <= rd_ok_next;
        cursor_index_reg <= cursor_index_next;
        read_data_reg    <= read_data_next;
        scrolled_reg     <= scrolled_next;
    end

    // Screen store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= mem[mem_raddr];
    end

    assign done         = done_reg;
    assign cursor_index = cursor_index_reg;
    assign read_data    = read_data_reg;
    assign scrolled     = scrolled_reg;

    // Checks.
    `TCW_ASSERT_SAME(a_cursor_range, 1'b1, cursor_reg <= CW'(CELLS),
                     "cursor beyond screen end")
    `TCW_ASSERT_SAME(a_done_idle, done, !busy, "result delivered while still busy")
    `TCW_ASSERT_NEXT(a_accept_busy, start && !busy && cmd != CMD_NOP, busy,
                     "command not started")
    `TCW_ASSERT_SAME(a_scroll_cursor, done && scrolled,
                     cursor_index == CW'(MOVE_CELLS) || cursor_index == CW'(MOVE_CELLS + 1),
                     "cursor off the last row after scroll")

endmodule

/* sim/console_checker.sv */
// Checker for the text console writer: watches the command and result ports,
// keeps its own copy of the screen and cursor, and compares every result item.
// Depends on tcw_pkg for geometry, cell words, control bytes and command codes.
module console_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic [1:0]             cmd,
    input  logic [7:0]             ch,
    input  logic [3:0]             background,
    input  logic [3:0]             foreground,
    input  logic [tcw_pkg::CW-1:0] cell_index,
    input  logic                   done,
    input  logic [tcw_pkg::CW-1:0] cursor_index,
    input  logic [15:0]            read_data,
    input  logic                   scrolled,
    output int                     fail_count,
    output int                     pending_count
);
    import tcw_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [CW-1:0] cursor;
        logic [15:0]   data;
        logic          scrolled;
    } console_result_t;

    // Shadow copy of the screen store and the cursor.
    logic [15:0]     screen_shadow [CELLS];
    int unsigned     cursor_shadow;
    console_result_t expected_results [$];

    // The cursor cell is only touched while the cursor is on the screen.
    function automatic void paint_cursor_cell(logic [15:0] word);
        if (cursor_shadow < CELLS)
            screen_shadow[cursor_shadow] = word;
    endfunction

    // A cursor that ran off the end moves every row up and blanks the last one.
    function automatic logic scroll_when_full();
        if (cursor_shadow < CELLS)
            return 1'b0;
        for (int i = 0; i < CELLS - COLUMNS; i++)
            screen_shadow[i] = screen_shadow[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
            screen_shadow[i] = '0;
        cursor_shadow = CELLS - COLUMNS;
        return 1'b1;
    endfunction

    // Applies one command item to the shadow state and returns its result item.
    function automatic console_result_t predict_console(logic [1:0] op, logic [7:0] c,
                                                        logic [3:0] bg, logic [3:0] fg,
                                                        logic [CW-1:0] idx);
        console_result_t r;
        r = '0;
        case (op)
            CMD_PUT:
            begin
                if (c == CH_BS)
                begin
                    // Backspace stops at the start of a row and leaves the cursor alone there.
                    if (cursor_shadow % COLUMNS != 0)
                    begin
                        paint_cursor_cell(BLANK_WORD);
                        cursor_shadow--;
                        paint_cursor_cell(CURSOR_WORD);
                    end
                end
                else
                begin
                    if (c == CH_TAB || c == CH_NL)
                    begin
                        paint_cursor_cell(BLANK_WORD);
                        if (c == CH_TAB)
                            cursor_shadow += TAB_STOP - cursor_shadow % TAB_STOP;
                        else
                            cursor_shadow += COLUMNS - cursor_shadow % COLUMNS;
                        r.scrolled = scroll_when_full();
                    end
                    else
                    begin
                        r.scrolled = scroll_when_full();
                        screen_shadow[cursor_shadow] = {bg, fg, c};
                        cursor_shadow++;
                    end
                    paint_cursor_cell(CURSOR_WORD);
                end
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    screen_shadow[i] = CLEAR_WORD;
                cursor_shadow = 0;
                paint_cursor_cell(CURSOR_WORD);
            end
            CMD_READ:
            begin
                if (idx < CELLS)
                    r.data = screen_shadow[idx];
            end
            default:
            begin
            end
        endcase
        r.cursor = cursor_shadow[CW-1:0];
        return r;
    endfunction

    // Compare leaving result items first, then predict the item taken at this edge.
    always @(posedge clk or negedge rst_n)
    begin
        console_result_t seen;
        console_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
                screen_shadow[i] = '0;
            cursor_shadow = 0;
            expected_results.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            if (done !== 1'b0)
            begin
                seen = {cursor_index, read_data, scrolled};
                if (expected_results.size() == 0)
                begin
                    if (fail_count < REPORT_LIMIT)
                        $display("unexpected result item: done %b cursor %0d data %h scrolled %b",
                                 done, cursor_index, read_data, scrolled);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (done !== 1'b1 || seen.cursor !== want.cursor
                        || seen.data !== want.data || seen.scrolled !== want.scrolled)
                    begin
                        if (fail_count < REPORT_LIMIT)
                            $display("result mismatch: cursor %0d/%0d data %h/%h scrolled %b/%b",
                                     want.cursor, seen.cursor, want.data, seen.data,
                                     want.scrolled, seen.scrolled);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(
                    predict_console(cmd, ch, background, foreground, cell_index));
            pending_count = expected_results.size();
        end
    end

endmodule

/* sim/tb_top.sv */
// Top of the text console writer testbench: clock, reset, command stimulus, verdict.
// Depends on tcw_pkg, text_console_writer_unit and console_checker.
module tb_top;
    import tcw_pkg::*;

    localparam int CYCLE_LIMIT  = 6_000_000;
    localparam int RANDOM_ITEMS = 750;
    localparam int TAIL_CYCLES  = 20;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          start;
    logic          busy;
    logic [1:0]    cmd;
    logic [7:0]    ch;
    logic [3:0]    background;
    logic [3:0]    foreground;
    logic [CW-1:0] cell_index;
    logic          done;
    logic [CW-1:0] cursor_index;
    logic [15:0]   read_data;
    logic          scrolled;
    int            fail_count;
    int            pending_count;
    int            items_sent = 0;
    int            cycle_count = 0;
    bit            steady = 1'b0;

    always #5 clk = ~clk;

    text_console_writer_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .ch           (ch),
        .background   (background),
        .foreground   (foreground),
        .cell_index   (cell_index),
        .done         (done),
        .cursor_index (cursor_index),
        .read_data    (read_data),
        .scrolled     (scrolled)
    );

    console_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .ch            (ch),
        .background    (background),
        .foreground    (foreground),
        .cell_index    (cell_index),
        .done          (done),
        .cursor_index  (cursor_index),
        .read_data     (read_data),
        .scrolled      (scrolled),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offers one command item after an optional idle gap and returns once it is taken.
    task automatic send_item(input logic [1:0] op, input logic [7:0] c,
                             input logic [3:0] bg, input logic [3:0] fg,
                             input logic [CW-1:0] idx);
        int gap;
        int roll;
        gap = 0;
        if (!steady)
        begin
            roll = $urandom_range(0, 99);
            if (roll >= 90)
                gap = $urandom_range(6, 40);
            else if (roll >= 55)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        cmd        <= op;
        ch         <= c;
        background <= bg;
        foreground <= fg;
        cell_index <= idx;
        // Busy is stable between the falling and the next rising edge.
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        items_sent++;
    endtask

    initial
    begin
        int         base;
        int         burst;
        int         len;
        logic [7:0] c;

        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = CMD_NOP;
        ch         = '0;
        background = '0;
        foreground = '0;
        cell_index = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items: fresh store, backspace at the row start, color and byte
        // extremes, each control, reads in and out of range, the unused command, clear.
        send_item(CMD_READ, 8'h00, 4'h0, 4'h0, '0);
        send_item(CMD_PUT, CH_BS, 4'h0, 4'h0, '0);
        send_item(CMD_PUT, 8'h41, 4'hF, 4'hF, '0);
        send_item(CMD_PUT, 8'h00, 4'h0, 4'h0, '0);
        send_item(CMD_PUT, 8'hFF, 4'hA, 4'h5, 11'h7FF);
        send_item(CMD_PUT, CH_BS, 4'h5, 4'hA, '0);
        send_item(CMD_PUT, CH_TAB, 4'h0, 4'h0, '0);
        send_item(CMD_PUT, CH_NL, 4'h0, 4'h0, '0);
        send_item(CMD_PUT, 8'h07, 4'h1, 4'h2, '0);
        send_item(CMD_PUT, 8'h0B, 4'h2, 4'h1, '0);
        send_item(CMD_READ, 8'h00, 4'h0, 4'h0, '0);
        send_item(CMD_READ, 8'h00, 4'h0, 4'h0, 11'd1);
        send_item(CMD_READ, 8'h00, 4'h0, 4'h0, 11'd80);
        send_item(CMD_READ, 8'h00, 4'h0, 4'h0, CW'(CELLS - 1));
        send_item(CMD_READ, 8'h00, 4'h0, 4'h0, CW'(CELLS));
        send_item(CMD_READ, 8'hFF, 4'hF, 4'hF, 11'h7FF);
        send_item(CMD_NOP, 8'h55, 4'h3, 4'hC, 11'h2AA);
        send_item(CMD_CLEAR, 8'hAA, 4'hC, 4'h3, 11'h555);
        send_item(CMD_READ, 8'h00, 4'h0, 4'h0, '0);
        send_item(CMD_READ, 8'h00, 4'h0, 4'h0, CW'(CELLS - 1));
        send_item(CMD_PUT, CH_BS, 4'h0, 4'h0, '0);

        // Random bursts: text lines, runs of controls, reads, the odd clear and noise.
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            steady = ($urandom_range(0, 4) == 0);
            burst  = $urandom_range(0, 99);
            if (burst < 45)
            begin
                // A line of printable text, sometimes longer than a row.
                len = $urandom_range(1, 90);
                for (int i = 0; i < len; i++)
                begin
                    c = 8'($urandom_range(0, 255));
                    if (c == CH_BS || c == CH_TAB || c == CH_NL)
                        c = 8'h20;
                    send_item(CMD_PUT, c, 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)), CW'($urandom_range(0, 2047)));
                end
                if ($urandom_range(0, 3) != 0)
                    send_item(CMD_PUT, CH_NL, 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)), CW'($urandom_range(0, 2047)));
            end
            else if (burst < 60)
            begin
                // Newline runs push the cursor to the bottom and then scroll.
                len = $urandom_range(1, 30);
                for (int i = 0; i < len; i++)
                    send_item(CMD_PUT, CH_NL, 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)), CW'($urandom_range(0, 2047)));
            end
            else if (burst < 70)
            begin
                len = $urandom_range(1, 24);
                for (int i = 0; i < len; i++)
                    send_item(CMD_PUT, CH_TAB, 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)), CW'($urandom_range(0, 2047)));
            end
            else if (burst < 78)
            begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    send_item(CMD_PUT, CH_BS, 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)), CW'($urandom_range(0, 2047)));
            end
            else if (burst < 90)
            begin
                // Reads across the whole address range, a share past the last cell.
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_item(CMD_READ, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)),
                              CW'(($urandom_range(0, 3) == 0) ? $urandom_range(CELLS, 2047)
                                                              : $urandom_range(0, CELLS - 1)));
            end
            else if (burst < 93)
            begin
                send_item(CMD_CLEAR, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                          4'($urandom_range(0, 15)), CW'($urandom_range(0, 2047)));
            end
            else
            begin
                // Noise: every field random, the unused command included.
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                              CW'($urandom_range(0, 2047)));
            end
        end
        start <= 1'b0;

        // Drain the outstanding result items, then allow a short tail for strays.
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
